@@ sv/pwmt_pkg.sv @@
// Package for the position weight matrix trainer.
// Holds widths, register indexes, defaults and the front-to-back command type.
package pwmt_pkg;

  localparam int unsigned NumPositionsDef = 16;
  localparam int unsigned CountWidthDef   = 16;
  localparam int unsigned NumBases        = 4;
  localparam int unsigned ProbW           = 17;
  localparam int unsigned SiteW           = 16;
  localparam int unsigned PosW            = 6;
  localparam int unsigned CfgIdxW         = 3;
  localparam int unsigned CfgDataW        = 17;

  localparam logic [ProbW-1:0] Q16One    = 17'd65536;
  localparam logic [ProbW-1:0] EquiProb  = 17'd16384;
  localparam logic [SiteW-1:0] SiteMax   = 16'hFFFF;

  localparam logic [CfgIdxW-1:0] RegInitCount     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegFaultThresh   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegFloorProb     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegProtectStart  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegProtectLen    = 3'd4;

  localparam logic [16:0] FaultThreshRst = 17'd655;
  localparam logic [14:0] FloorProbRst   = 15'd66;

  localparam logic OpAdd  = 1'b0;
  localparam logic OpEmit = 1'b1;

  typedef struct packed {
    logic       emit;
    logic [1:0] nucleotide;
  } cmd_t;

  typedef enum logic [2:0] {
    StIdle,
    StAdd,
    StRead,
    StLoad,
    StDiv,
    StScale,
    StOut
  } back_state_e;

endpackage

@@ sv/pwmt_front.sv @@
// Front part of the trainer: accepts input transfers and queues commands.
// Depends on pwmt_pkg.
module pwmt_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 opcode_i,
  input  logic [1:0]           nucleotide_i,
  output logic                 cmd_valid_o,
  input  logic                 cmd_ready_i,
  output pwmt_pkg::cmd_t       cmd_o
);

  pwmt_pkg::cmd_t fifo_q [2];
  logic           wr_q, rd_q;
  logic [1:0]     cnt_q;
  logic           push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q].emit       <= (opcode_i == pwmt_pkg::OpEmit);
      fifo_q[wr_q].nucleotide <= nucleotide_i;
    end
  end

endmodule

@@ sv/pwmt_back.sv @@
// Back part of the trainer: count memory, site counter, divider and smoothing.
// Depends on pwmt_pkg.
module pwmt_back #(
  parameter int unsigned NUM_POSITIONS = pwmt_pkg::NumPositionsDef,
  parameter int unsigned COUNT_WIDTH   = pwmt_pkg::CountWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  output logic                 cmd_ready_o,
  input  pwmt_pkg::cmd_t       cmd_i,
  input  logic                 cfg_valid_i,
  input  logic [2:0]           cfg_index_i,
  input  logic [16:0]          cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [5:0]           position_o,
  output logic [16:0]          prob_a_o,
  output logic [16:0]          prob_c_o,
  output logic [16:0]          prob_g_o,
  output logic [16:0]          prob_t_o,
  output logic                 last_row_o
);

  localparam int unsigned AW   = (NUM_POSITIONS > 1) ? $clog2(NUM_POSITIONS) : 1;
  localparam int unsigned NumW = COUNT_WIDTH + 16;
  localparam int unsigned DivCntW = $clog2(NumW + 1);
  localparam logic [AW-1:0] LastPos = AW'(NUM_POSITIONS - 1);
  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  logic [7:0]  init_q;
  logic [16:0] thr_q;
  logic [14:0] floor_q;
  logic [5:0]  pstart_q;
  logic [6:0]  plen_q;

  logic [COUNT_WIDTH-1:0] mem_q [NUM_POSITIONS*4];
  logic [NUM_POSITIONS*4-1:0] vld_q;
  logic [15:0] site_q;
  logic [AW-1:0] pos_q;

  pwmt_pkg::back_state_e st_q, st_d;
  logic [AW-1:0] row_q;
  logic [1:0]    lane_q;
  logic [COUNT_WIDTH-1:0] rd_q;
  logic [NumW-1:0] quo_q;
  logic [16:0]     rem_q;
  logic [DivCntW-1:0] bit_q;
  logic [16:0] p_q [4];
  logic [1:0]  sc_q;
  logic [3:0]  low_q;

  logic [AW+1:0] addr_add, addr_rd;
  logic [COUNT_WIDTH-1:0] cur;
  logic cfg_init;

  assign addr_add = {pos_q, cmd_i.nucleotide};
  assign addr_rd  = {row_q, lane_q};
  assign cfg_init = cfg_valid_i && (cfg_index_i == pwmt_pkg::RegInitCount);
  assign cur = vld_q[addr_add] ? rd_q : COUNT_WIDTH'(init_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q   <= '0;
      thr_q    <= pwmt_pkg::FaultThreshRst;
      floor_q  <= pwmt_pkg::FloorProbRst;
      pstart_q <= '0;
      plen_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pwmt_pkg::RegInitCount:    init_q   <= cfg_data_i[7:0];
        pwmt_pkg::RegFaultThresh:  thr_q    <= cfg_data_i;
        pwmt_pkg::RegFloorProb:    floor_q  <= cfg_data_i[14:0];
        pwmt_pkg::RegProtectStart: pstart_q <= cfg_data_i[5:0];
        pwmt_pkg::RegProtectLen:   plen_q   <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // smoothing helpers
  logic [3:0]  low;
  logic [3:0]  lowm;
  logic [2:0]  nlow;
  logic        prot;
  logic [18:0] four_floor;
  logic [16:0] scale;
  logic [33:0] prod;
  logic [17:0] sm;
  logic [6:0]  row_ext;

  assign row_ext = 7'(row_q);
  assign prot = (row_ext >= {1'b0, pstart_q}) &&
                ({1'b0, row_ext} < ({2'b0, pstart_q} + {1'b0, plen_q}));
  assign four_floor = {2'b00, floor_q, 2'b00};
  assign scale = (four_floor >= 19'd65536) ? '0 : 17'(19'd65536 - four_floor);
  assign prod  = p_q[sc_q] * scale;
  assign sm    = 18'(prod[33:16]) + 18'(floor_q);

  always_comb begin
    nlow = '0;
    for (int j = 0; j < 4; j++) begin
      low[j] = p_q[j] < thr_q;
    end
    lowm = (sc_q == 2'd0) ? low : low_q;
    for (int j = 0; j < 4; j++) begin
      nlow = nlow + 3'(lowm[j]);
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      pwmt_pkg::StIdle:  if (cmd_valid_i) st_d = cmd_i.emit ?
                           pwmt_pkg::StRead : pwmt_pkg::StAdd;
      pwmt_pkg::StAdd:   st_d = pwmt_pkg::StIdle;
      pwmt_pkg::StRead:  st_d = pwmt_pkg::StLoad;
      pwmt_pkg::StLoad:  st_d = pwmt_pkg::StDiv;
      pwmt_pkg::StDiv:   if (bit_q == '0) st_d = (lane_q == 2'd3) ?
                           pwmt_pkg::StScale : pwmt_pkg::StRead;
      pwmt_pkg::StScale: if (prot || nlow == 3'd0 || nlow == 3'd4 || sc_q == 2'd3)
                           st_d = pwmt_pkg::StOut;
      pwmt_pkg::StOut:   if (out_ready_i) st_d = (row_q == LastPos) ?
                           pwmt_pkg::StIdle : pwmt_pkg::StRead;
      default: st_d = pwmt_pkg::StIdle;
    endcase
  end

  assign cmd_ready_o = (st_q == pwmt_pkg::StAdd) ||
                       (st_q == pwmt_pkg::StOut && out_ready_i && row_q == LastPos);
  assign out_valid_o = (st_q == pwmt_pkg::StOut);
  assign position_o  = 6'(row_q);
  assign last_row_o  = (row_q == LastPos);
  assign prob_a_o = p_q[0];
  assign prob_c_o = p_q[1];
  assign prob_g_o = p_q[2];
  assign prob_t_o = p_q[3];

  logic [17:0] rem_sh;
  assign rem_sh = {rem_q, quo_q[NumW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= pwmt_pkg::StIdle;
      vld_q  <= '0;
      site_q <= '0;
      pos_q  <= '0;
      row_q  <= '0;
      lane_q <= '0;
      sc_q   <= '0;
      bit_q  <= '0;
      low_q  <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_init) vld_q <= '0;
      unique case (st_q)
        pwmt_pkg::StIdle: begin
          row_q <= '0;
          lane_q <= '0;
        end
        pwmt_pkg::StAdd: begin
          vld_q[addr_add] <= 1'b1;
          if (pos_q == LastPos) begin
            pos_q <= '0;
            if (site_q != pwmt_pkg::SiteMax) site_q <= site_q + 16'd1;
          end else begin
            pos_q <= pos_q + AW'(1);
          end
        end
        pwmt_pkg::StLoad: bit_q <= DivCntW'(NumW);
        pwmt_pkg::StDiv: begin
          if (bit_q != '0) bit_q <= bit_q - DivCntW'(1);
          else begin
            lane_q <= lane_q + 2'd1;
            sc_q   <= '0;
          end
        end
        pwmt_pkg::StScale: begin
          sc_q <= sc_q + 2'd1;
          if (sc_q == 2'd0) low_q <= low;
        end
        pwmt_pkg::StOut: if (out_ready_i) begin
          if (row_q == LastPos) begin
            vld_q  <= '0;
            site_q <= '0;
            pos_q  <= '0;
          end else begin
            row_q <= row_q + AW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == pwmt_pkg::StAdd) begin
      mem_q[addr_add] <= (cur == CountMax) ? cur : cur + COUNT_WIDTH'(1);
    end
    if (st_q == pwmt_pkg::StRead) begin
      rd_q <= mem_q[addr_rd];
    end else if (st_q == pwmt_pkg::StIdle) begin
      rd_q <= mem_q[addr_add];
    end
    unique case (st_q)
      pwmt_pkg::StLoad: begin
        quo_q <= {(vld_q[addr_rd] ? rd_q : COUNT_WIDTH'(init_q)), 16'd0};
        rem_q <= '0;
      end
      pwmt_pkg::StDiv: begin
        if (bit_q != '0) begin
          if (rem_sh >= {2'b0, site_q}) begin
            rem_q <= 17'(rem_sh - {2'b0, site_q});
            quo_q <= {quo_q[NumW-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh[16:0];
            quo_q <= {quo_q[NumW-2:0], 1'b0};
          end
        end else if (site_q == '0) begin
          p_q[lane_q] <= pwmt_pkg::EquiProb;
        end else begin
          p_q[lane_q] <= (quo_q > NumW'(pwmt_pkg::Q16One)) ? pwmt_pkg::Q16One :
                         quo_q[16:0];
        end
      end
      pwmt_pkg::StScale: begin
        if (!prot && nlow == 3'd4) begin
          for (int j = 0; j < 4; j++) p_q[j] <= pwmt_pkg::EquiProb;
        end else if (!prot && nlow != 3'd0) begin
          if (lowm[sc_q]) p_q[sc_q] <= 17'(floor_q);
          else p_q[sc_q] <= (sm > 18'(pwmt_pkg::Q16One)) ? pwmt_pkg::Q16One : sm[16:0];
        end
      end
      default: ;
    endcase
  end

endmodule

@@ sv/position_weight_matrix_trainer.sv @@
// Top level of the position weight matrix trainer.
// Depends on pwmt_pkg, pwmt_front and pwmt_back.
//
// Channels: s_axis carries input items, tdata {nucleotide[1:0]}, tuser {opcode}.
// m_axis carries one row per position, tdata from bit 0 up: position (6),
// prob_a, prob_c, prob_g, prob_t (17 each), zero filled to 80 bits; tlast
// is last_row. cfg writes register cfg_index_i with cfg_data_i; the user must
// write only while idle, as the block itself does not enforce it. Add items
// read the count in the back part, then write it back; a two-entry queue sits
// ahead so the input side keeps taking transfers. An emit leaves idle and then
// produces NUM_POSITIONS rows. Each row reads, loads and serially divides each
// of the four lanes, then smooths them at once (protected, all low or none
// low) or one lane at a time through the single 17x17 multiplier, and holds
// the row in the output state until m_axis takes it.
// A stalled m_axis holds the row; the back part waits, the queue fills, and
// s_axis_tready falls once the queue is full.
// Reset clears the queue, site count and position, and marks every count
// invalid so it reads as init_count; registers return to their defaults.
module position_weight_matrix_trainer #(
  parameter int unsigned NUM_POSITIONS = pwmt_pkg::NumPositionsDef,
  parameter int unsigned COUNT_WIDTH   = pwmt_pkg::CountWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // nucleotide[1:0]
  input  logic        s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // position, prob_a, prob_c, prob_g, prob_t
  output logic        m_axis_tlast,   // last_row
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i
);

  logic           cmd_valid, cmd_ready;
  pwmt_pkg::cmd_t cmd;
  logic [5:0]     pos;
  logic [16:0]    pa, pc, pg, pt;

  assign cfg_ready_o = 1'b1;
  assign m_axis_tdata = {6'd0, pt, pg, pc, pa, pos};

  pwmt_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .opcode_i     (s_axis_tuser),
    .nucleotide_i (s_axis_tdata[1:0]),
    .cmd_valid_o  (cmd_valid),
    .cmd_ready_i  (cmd_ready),
    .cmd_o        (cmd)
  );

  pwmt_back #(.NUM_POSITIONS(NUM_POSITIONS), .COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .position_o  (pos),
    .prob_a_o    (pa),
    .prob_c_o    (pc),
    .prob_g_o    (pg),
    .prob_t_o    (pt),
    .last_row_o  (m_axis_tlast)
  );

endmodule
